// ===== hw/rtl/lscr_pkg.sv =====
`default_nettype none

package lscr_pkg;

  // Fixed field widths of the block.
  localparam int unsigned CW  = 11;          // count register width
  localparam int unsigned PIW = 10;          // position field width
  localparam int unsigned CHW = 8;           // one color channel
  localparam int unsigned COLW = 3 * CHW;    // one stored RGB entry
  localparam int unsigned PW  = 2 * CW;      // LED index times source span
  localparam int unsigned QW  = CW;          // quotient bits of the index divide
  localparam int unsigned NW  = CHW + CW + 1; // blend numerator width
  localparam int unsigned IXW = 2;           // config register index width

  localparam int unsigned MAX_SOURCES_DEF = 1024;
  localparam int unsigned MAX_LEDS_DEF    = 1024;
  localparam logic [CW-1:0] COUNT_RST     = 11'd1024;

  // Configuration register indexes.
  typedef enum logic [IXW-1:0] {
    CfgLedCount    = 2'd0,
    CfgSourceCount = 2'd1
  } cfg_reg_e;

  // Control that travels with an item through the index divider.
  typedef struct packed {
    logic            is_req;
    logic            oor;
    logic            blend;
    logic [PIW-1:0]  pos;
    logic [COLW-1:0] color;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lscr_if.sv =====
`default_nettype none

// Input channel: source writes and LED requests.
interface lscr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [lscr_pkg::PIW-1:0]  position;
  logic [lscr_pkg::CHW-1:0]  red_in;
  logic [lscr_pkg::CHW-1:0]  green_in;
  logic [lscr_pkg::CHW-1:0]  blue_in;
  modport source (output valid, action, position, red_in, green_in, blue_in, input ready);
  modport sink (input valid, action, position, red_in, green_in, blue_in, output ready);
endinterface

// Output channel: one LED color per request.
interface lscr_out_if;
  logic                      valid;
  logic                      ready;
  logic [lscr_pkg::CHW-1:0]  red;
  logic [lscr_pkg::CHW-1:0]  green;
  logic [lscr_pkg::CHW-1:0]  blue;
  logic                      out_of_range;
  modport source (output valid, red, green, blue, out_of_range, input ready);
  modport sink (input valid, red, green, blue, out_of_range, output ready);
endinterface

// Configuration write channel.
interface lscr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lscr_pkg::IXW-1:0]  index;
  logic [lscr_pkg::CW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lscr_ram.sv =====
`default_nettype none

module lscr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/led_strip_color_resampler.sv =====
// LED strip color resampler. Write beats (action 0) store one RGB source color at
// the given entry; request beats (action 1) return the color of one LED, blended
// linearly between neighboring source colors when the strip has more LEDs than
// sources, or picked from the nearest lower source otherwise. The block takes one
// beat per cycle while results are taken. A request passes one product stage,
// eleven index divider stages, one memory read, one weight stage and eight blend
// divider stages, the last of which is the output register. The whole pipeline
// holds while a result waits to be taken. Writes share the stages up to the store
// with requests, so every request sees exactly the writes accepted before it.
// Change led_count and source_count only while no beat is in flight.
`default_nettype none

module led_strip_color_resampler #(
  parameter int unsigned MAX_SOURCES = lscr_pkg::MAX_SOURCES_DEF,
  parameter int unsigned MAX_LEDS    = lscr_pkg::MAX_LEDS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lscr_cfg_if.sink   cfg_i,
  lscr_in_if.sink    in_i,
  lscr_out_if.source out_o
);

  localparam int unsigned CW   = lscr_pkg::CW;
  localparam int unsigned PW   = lscr_pkg::PW;
  localparam int unsigned QW   = lscr_pkg::QW;
  localparam int unsigned NW   = lscr_pkg::NW;
  localparam int unsigned CHW  = lscr_pkg::CHW;
  localparam int unsigned COLW = lscr_pkg::COLW;
  localparam int unsigned AW   = $clog2(MAX_SOURCES);

  // Configuration registers.
  logic [CW-1:0] led_count_q, source_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q    <= lscr_pkg::COUNT_RST;
      source_count_q <= lscr_pkg::COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lscr_pkg::CfgLedCount:    led_count_q    <= cfg_i.data;
        lscr_pkg::CfgSourceCount: source_count_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Effective counts saturate to the range from 2 to MAX_LEDS or MAX_SOURCES.
  logic [CW-1:0] led_eff, src_eff, l1, s1;
  logic          blend_mode;

  always_comb begin
    if (led_count_q < CW'(2)) begin
      led_eff = CW'(2);
    end else if (32'(led_count_q) > MAX_LEDS) begin
      led_eff = CW'(MAX_LEDS);
    end else begin
      led_eff = led_count_q;
    end
    if (source_count_q < CW'(2)) begin
      src_eff = CW'(2);
    end else if (32'(source_count_q) > MAX_SOURCES) begin
      src_eff = CW'(MAX_SOURCES);
    end else begin
      src_eff = source_count_q;
    end
    l1         = led_eff - CW'(1);
    s1         = src_eff - CW'(1);
    blend_mode = led_eff > src_eff;
  end

  // One enable moves every stage; the output register frees when taken.
  logic en;
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Product stage: position times the source span.
  logic                 p_v_q;
  lscr_pkg::ctl_t       p_ctl_q;
  logic [PW-1:0]        p_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ctl_q.is_req <= in_i.action;
      p_ctl_q.oor    <= CW'(in_i.position) >= led_eff;
      p_ctl_q.blend  <= blend_mode;
      p_ctl_q.pos    <= in_i.position;
      p_ctl_q.color  <= {in_i.red_in, in_i.green_in, in_i.blue_in};
      p_prod_q       <= PW'(in_i.position) * PW'(s1);
    end
  end

  // Index divider: one quotient bit per stage, restoring.
  logic           d_v_q   [QW];
  lscr_pkg::ctl_t d_ctl_q [QW];
  logic [PW-1:0]  d_rem_q [QW];
  logic [QW-1:0]  d_quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic           v_in;
    lscr_pkg::ctl_t ctl_in;
    logic [PW-1:0]  rem_in;
    logic [QW-1:0]  quo_in;
    logic [QW-1:0]  quo_out;
    logic [PW:0]    dsh;
    logic           take;

    if (k == 0) begin : g_first
      assign v_in   = p_v_q;
      assign ctl_in = p_ctl_q;
      assign rem_in = p_prod_q;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = d_v_q[k-1];
      assign ctl_in = d_ctl_q[k-1];
      assign rem_in = d_rem_q[k-1];
      assign quo_in = d_quo_q[k-1];
    end

    assign dsh     = (PW+1)'(l1) << (QW-1-k);
    assign take    = {1'b0, rem_in} >= dsh;
    assign quo_out = quo_in | (QW'(take) << (QW-1-k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v_q[k] <= 1'b0;
      end else if (en) begin
        d_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d_ctl_q[k] <= ctl_in;
        d_rem_q[k] <= take ? PW'({1'b0, rem_in} - dsh) : rem_in;
        d_quo_q[k] <= quo_out;
      end
    end
  end

  // Source store: two copies so that both neighbors read in the same cycle.
  logic           dl_v;
  lscr_pkg::ctl_t dl_ctl;
  logic [QW-1:0]  dl_q;
  logic [CW-1:0]  dl_r;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [COLW-1:0] rd_a, rd_b;

  assign dl_v      = d_v_q[QW-1];
  assign dl_ctl    = d_ctl_q[QW-1];
  assign dl_q      = d_quo_q[QW-1];
  assign dl_r      = d_rem_q[QW-1][CW-1:0];
  assign ram_we    = en && dl_v && !dl_ctl.is_req && (32'(dl_ctl.pos) < MAX_SOURCES);
  assign ram_waddr = AW'(dl_ctl.pos);

  lscr_ram #(.WIDTH(COLW), .DEPTH(MAX_SOURCES)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (dl_ctl.color),
    .re_i    (en),
    .raddr_i (AW'(dl_q)),
    .rdata_o (rd_a)
  );

  lscr_ram #(.WIDTH(COLW), .DEPTH(MAX_SOURCES)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (dl_ctl.color),
    .re_i    (en),
    .raddr_i (AW'(dl_q + QW'(1))),
    .rdata_o (rd_b)
  );

  // Memory stage: requests only from here on.
  logic          m_v_q, m_oor_q, m_blend_q;
  logic [CW-1:0] m_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= dl_v && dl_ctl.is_req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_oor_q   <= dl_ctl.oor;
      m_blend_q <= dl_ctl.blend;
      m_r_q     <= dl_r;
    end
  end

  // Weight stage. A pick is a blend with all weight on the lower source.
  logic [CW-1:0]   wa, wb;
  logic [COLW-1:0] b_m;
  logic [NW-1:0]   num [3];
  logic            x_v_q, x_oor_q;
  logic [NW-1:0]   x_num_q [3];

  always_comb begin
    if (m_blend_q) begin
      wa = l1 - m_r_q;
      wb = m_r_q;
    end else begin
      wa = l1;
      wb = '0;
    end
    b_m = (wb != '0) ? rd_b : '0;
    for (int c = 0; c < 3; c++) begin
      num[c] = NW'(rd_a[c*CHW +: CHW]) * NW'(wa) + NW'(b_m[c*CHW +: CHW]) * NW'(wb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_v_q <= 1'b0;
    end else if (en) begin
      x_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_oor_q <= m_oor_q;
      for (int c = 0; c < 3; c++) begin
        x_num_q[c] <= num[c];
      end
    end
  end

  // Blend divider: one result bit per stage, three channels side by side.
  logic           e_v_q   [CHW];
  logic           e_oor_q [CHW];
  logic [NW-1:0]  e_rem_q [CHW][3];
  logic [CHW-1:0] e_quo_q [CHW][3];

  for (genvar j = 0; j < CHW; j++) begin : g_blend
    logic v_in, oor_in;
    logic [NW:0] dsh;

    if (j == 0) begin : g_first
      assign v_in   = x_v_q;
      assign oor_in = x_oor_q;
    end else begin : g_next
      assign v_in   = e_v_q[j-1];
      assign oor_in = e_oor_q[j-1];
    end

    assign dsh = (NW+1)'(l1) << (CHW-1-j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        e_v_q[j] <= 1'b0;
      end else if (en) begin
        e_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_oor_q[j] <= oor_in;
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
      logic [NW-1:0]  rem_in;
      logic [CHW-1:0] quo_in;
      logic [CHW-1:0] quo_out;
      logic           take;

      if (j == 0) begin : g_first
        assign rem_in = x_num_q[c];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = e_rem_q[j-1][c];
        assign quo_in = e_quo_q[j-1][c];
      end

      assign take    = {1'b0, rem_in} >= dsh;
      assign quo_out = quo_in | (CHW'(take) << (CHW-1-j));

      always_ff @(posedge clk_i) begin
        if (en) begin
          e_rem_q[j][c] <= take ? NW'({1'b0, rem_in} - dsh) : rem_in;
          e_quo_q[j][c] <= quo_out;
        end
      end
    end
  end

  // Output. Channel 2 holds red, channel 0 blue.
  assign out_o.valid        = e_v_q[CHW-1];
  assign out_o.out_of_range = e_oor_q[CHW-1];
  assign out_o.red   = e_oor_q[CHW-1] ? '0 : e_quo_q[CHW-1][2];
  assign out_o.green = e_oor_q[CHW-1] ? '0 : e_quo_q[CHW-1][1];
  assign out_o.blue  = e_oor_q[CHW-1] ? '0 : e_quo_q[CHW-1][0];

  // For an in-range request the index divide leaves a remainder below the LED span.
  a_idx_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_v_q[QW-1] && d_ctl_q[QW-1].is_req && !d_ctl_q[QW-1].oor) |->
      (d_rem_q[QW-1] < PW'(l1)))
    else $error("index remainder not below LED span");

  // For an in-range request the blend divide leaves a remainder below the LED span.
  a_blend_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_v_q[CHW-1] && !e_oor_q[CHW-1]) |->
      (e_rem_q[CHW-1][0] < NW'(l1) && e_rem_q[CHW-1][1] < NW'(l1) &&
       e_rem_q[CHW-1][2] < NW'(l1)))
    else $error("blend remainder not below LED span");

  // A store write never happens in the same cycle as a stalled pipeline.
  a_we_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (en && !dl_ctl.is_req))
    else $error("store written during stall or by a request");

  // An out-of-range result is black.
  a_oor_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.out_of_range) |->
      (out_o.red == '0 && out_o.green == '0 && out_o.blue == '0))
    else $error("out-of-range result not black");

endmodule

`default_nettype wire

// ===== tb/sv/tb_led_strip_color_resampler.sv =====
`default_nettype none

module tb_led_strip_color_resampler;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned STRIP_MAX   = 1024;
  localparam int unsigned PIPE_DRAIN  = 40;

  // Action codes of an input beat.
  typedef enum logic {
    ActWrite   = 1'b0,
    ActRequest = 1'b1
  } action_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_of_range;
  } led_color_t;

  logic clk_i;
  logic rst_ni;

  lscr_cfg_if cfg_bus ();
  lscr_in_if  in_bus ();
  lscr_out_if out_bus ();

  led_strip_color_resampler i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus.sink),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  // Model state: the source row, which entries were written, the count registers.
  logic [23:0]   source_row [STORE_DEPTH];
  bit            row_written [STORE_DEPTH];
  logic [10:0]   led_reg;
  logic [10:0]   src_reg;
  led_color_t    expected_colors[$];
  int            mismatch_count;
  bit            timed_out;
  bit            stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the whole run.
  initial begin
    #20ms;
    $display("** led_strip_color_resampler: FAILED **");
    $finish;
  end

  function automatic int unsigned eff_count(logic [10:0] v, int unsigned max_v);
    if (v < 2) return 2;
    if (32'(v) > max_v) return max_v;
    return 32'(v);
  endfunction

  function automatic led_color_t resample_led(logic [9:0] pos);
    int unsigned leds, srcs, l1, prod, q, r;
    logic [23:0] a, b;
    led_color_t res;
    leds = eff_count(led_reg, STRIP_MAX);
    srcs = eff_count(src_reg, STORE_DEPTH);
    res = '0;
    if (pos >= leds) begin
      res.out_of_range = 1'b1;
      return res;
    end
    l1 = leds - 1;
    prod = pos * (srcs - 1);
    q = prod / l1;
    r = prod % l1;
    if (leds > srcs) begin
      a = source_row[q];
      b = (r != 0) ? source_row[q + 1] : 24'h0;
      res.red   = 8'(((a[23:16] * (l1 - r)) + b[23:16] * r) / l1);
      res.green = 8'(((a[15:8] * (l1 - r)) + b[15:8] * r) / l1);
      res.blue  = 8'(((a[7:0] * (l1 - r)) + b[7:0] * r) / l1);
    end else if (leds < srcs) begin
      {res.red, res.green, res.blue} = source_row[q];
    end else begin
      {res.red, res.green, res.blue} = source_row[pos];
    end
    return res;
  endfunction

  // Sources that a request at pos reads; the request is legal only if all were written.
  function automatic bit request_safe(logic [9:0] pos);
    int unsigned leds, srcs, l1, prod, q;
    leds = eff_count(led_reg, STRIP_MAX);
    srcs = eff_count(src_reg, STORE_DEPTH);
    if (pos >= leds) return 1;
    l1 = leds - 1;
    prod = pos * (srcs - 1);
    q = prod / l1;
    if (leds == srcs) return row_written[pos];
    if (leds > srcs && (prod % l1) != 0) return row_written[q] && row_written[q + 1];
    return row_written[q];
  endfunction

  // Sends one beat and updates the model when it is accepted. Valid stays high
  // afterwards so that the next beat can follow at once; idling drops it.
  task automatic send_beat(action_e act, logic [9:0] pos, logic [23:0] rgb);
    in_bus.valid    <= 1'b1;
    in_bus.action   <= act;
    in_bus.position <= pos;
    {in_bus.red_in, in_bus.green_in, in_bus.blue_in} <= rgb;
    do @(posedge clk_i); while (!in_bus.ready);
    if (act == ActWrite) begin
      source_row[pos] = rgb;
      row_written[pos] = 1'b1;
    end else begin
      expected_colors.push_back(resample_led(pos));
    end
    @(negedge clk_i);
  endtask

  // Random gap between bursts, or none.
  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic write_register(lscr_pkg::cfg_reg_e idx, logic [10:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == lscr_pkg::CfgLedCount) led_reg = value;
    else src_reg = value;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    int guard;
    in_bus.valid <= 1'b0;
    guard = 0;
    while (expected_colors.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_colors.size() != 0) begin
      timed_out = 1'b1;
    end
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  task automatic set_counts(logic [10:0] leds, logic [10:0] srcs);
    wait_idle();
    write_register(lscr_pkg::CfgLedCount, leds);
    write_register(lscr_pkg::CfgSourceCount, srcs);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic fill_row(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      send_beat(ActWrite, k[9:0], 24'($urandom()));
      sender_gap();
    end
  endtask

  // Directed: extreme colors, edges of the strip, out-of-range and unread beats.
  task automatic test_directed();
    set_counts(11'd8, 11'd3);
    send_beat(ActWrite, 10'd0, 24'hFFFFFF);
    send_beat(ActWrite, 10'd1, 24'h000000);
    send_beat(ActWrite, 10'd2, 24'hA5C33C);
    send_beat(ActWrite, 10'd1023, 24'h5A3CC3);
    for (int unsigned p = 0; p < 8; p++) send_beat(ActRequest, p[9:0], 24'h0);
    send_beat(ActRequest, 10'd8, 24'hFFFFFF);
    send_beat(ActRequest, 10'd1023, 24'h0);
    set_counts(11'd3, 11'd8);
    fill_row(8);
    for (int unsigned p = 0; p < 3; p++) send_beat(ActRequest, p[9:0], 24'h0);
    set_counts(11'd0, 11'd1);
    send_beat(ActRequest, 10'd1, 24'h0);
    send_beat(ActRequest, 10'd2, 24'h0);
  endtask

  // Full-size row with register values beyond the legal range.
  task automatic test_extremes();
    set_counts(11'd2047, 11'd1024);
    fill_row(1024);
    send_beat(ActRequest, 10'd0, 24'h0);
    send_beat(ActRequest, 10'd1023, 24'h0);
    set_counts(11'd1024, 11'd2047);
    send_beat(ActRequest, 10'd511, 24'h0);
    set_counts(11'd2, 11'd1024);
    send_beat(ActRequest, 10'd1, 24'h0);
    set_counts(11'd1024, 11'd2);
    for (int k = 0; k < 20; k++) send_beat(ActRequest, 10'($urandom()), 24'h0);
  endtask

  // Random counts from 2 to 40, with mixed writes and requests.
  task automatic test_random();
    int unsigned leds, srcs, span;
    logic [9:0] pos;
    for (int phase = 0; phase < 8; phase++) begin
      leds = $urandom_range(2, 40);
      srcs = $urandom_range(2, 40);
      set_counts(leds[10:0], srcs[10:0]);
      for (int k = 0; k < 50; k++) begin
        span = (leds > srcs ? leds : srcs) + 2;
        if ($urandom_range(0, 2) == 0) begin
          pos = $urandom_range(0, 9) == 0 ? 10'($urandom()) : 10'($urandom_range(0, span));
          send_beat(ActWrite, pos, 24'($urandom()));
        end else begin
          pos = $urandom_range(0, 9) == 0 ? 10'($urandom()) : 10'($urandom_range(0, span));
          if (request_safe(pos)) send_beat(ActRequest, pos, 24'($urandom()));
        end
        sender_gap();
      end
    end
  endtask

  // Receiver stalls, mixed at random: none, light, heavy.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!stall_enable) begin
        out_bus.ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 2))
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin
    led_color_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = {out_bus.red, out_bus.green, out_bus.blue, out_bus.out_of_range};
      if (expected_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_colors.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("color mismatch: expected r %h g %h b %h oor %b, got r %h g %h b %h oor %b",
                     want.red, want.green, want.blue, want.out_of_range,
                     got.red, got.green, got.blue, got.out_of_range);
          end
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    timed_out = 1'b0;
    stall_enable = 1'b1;
    led_reg = lscr_pkg::COUNT_RST;
    src_reg = lscr_pkg::COUNT_RST;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = lscr_pkg::CfgLedCount;
    cfg_bus.data = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ActWrite;
    in_bus.position = '0;
    in_bus.red_in = '0;
    in_bus.green_in = '0;
    in_bus.blue_in = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_extremes();
    test_random();
    wait_idle();
    if (mismatch_count == 0 && !timed_out && expected_colors.size() == 0) begin
      $display("** led_strip_color_resampler: PASSED **");
    end else begin
      $display("** led_strip_color_resampler: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== led_strip_color_resampler.f =====
hw/rtl/lscr_pkg.sv
hw/rtl/lscr_if.sv
hw/rtl/lscr_ram.sv
hw/rtl/led_strip_color_resampler.sv
tb/sv/tb_led_strip_color_resampler.sv
